// File: design/bdar_pkg.sv
package bdar_pkg;

   // tick counter width and width of the tick registers
   localparam int TICK_W = 16;
   localparam int CFG_W = 16;
   localparam int CMP_W = (TICK_W > CFG_W) ? TICK_W : CFG_W;
   localparam int MODE_W = 2;
   localparam int IDX_W = 3;

   typedef logic [TICK_W-1:0] tick_type;
   typedef logic [CFG_W-1:0] cfg_word_type;
   typedef logic [CMP_W-1:0] cmp_type;
   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [IDX_W-1:0] idx_type;

   localparam tick_type TICK_MAX = '1;

   // register indexes
   localparam idx_type REG_DEBOUNCE = 3'd0;
   localparam idx_type REG_REPEAT = 3'd1;
   localparam idx_type REG_MODE = 3'd2;
   localparam idx_type REG_ACCEL_START = 3'd3;
   localparam idx_type REG_ACCEL_FLOOR = 3'd4;
   localparam idx_type REG_ACCEL_THRESH = 3'd5;

   // event modes
   localparam mode_type MODE_EDGE = 2'd0;
   localparam mode_type MODE_REPEAT = 2'd1;
   localparam mode_type MODE_LEVEL = 2'd2;
   localparam mode_type MODE_ACCEL = 2'd3;

   // reset values of the registers
   localparam cfg_word_type DEBOUNCE_RST = 16'd50;
   localparam cfg_word_type REPEAT_RST = 16'd250;
   localparam mode_type MODE_RST = MODE_EDGE;
   localparam cfg_word_type ACCEL_START_RST = 16'd2000;
   localparam cfg_word_type ACCEL_FLOOR_RST = 16'd50;
   localparam cfg_word_type ACCEL_THRESH_RST = 16'd100;

   typedef struct packed {
      cfg_word_type debounce_ticks;
      cfg_word_type repeat_ticks;
      mode_type event_mode;
      cfg_word_type accel_start_ticks;
      cfg_word_type accel_floor_ticks;
      cfg_word_type accel_threshold_ticks;
   } cfg_type;

   typedef struct packed {
      logic level;
      logic release_pulse;
   } deb_out_type;

   typedef struct packed {
      logic edge_ev;
      logic rep_ev;
      logic acc_ev;
   } rpt_ev_type;

   // saturating increment of a tick counter
   function automatic tick_type sat_inc(input tick_type v);
      return (v == TICK_MAX) ? v : tick_type'(v + 1'b1);
   endfunction

endpackage

// File: design/bdar_debounce.sv
module bdar_debounce
   import bdar_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic         touch_hit,
   input  cfg_word_type debounce_ticks,
   output deb_out_type  deb_out
);

   logic     level_ff, level_in;
   tick_type since_press_ff, since_press_in;
   tick_type since_hit_ff, since_hit_in;
   tick_type press_inc, hit_inc;
   logic     hold_press, hold_hit;

   // hold rule on the advanced counters
   always_comb begin
      press_inc = sat_inc(since_press_ff);
      hit_inc = sat_inc(since_hit_ff);
      hold_press = (press_inc != TICK_MAX) &&
                   (cmp_type'(press_inc) <= cmp_type'(debounce_ticks));
      hold_hit = (hit_inc != TICK_MAX) &&
                 (cmp_type'(hit_inc) < cmp_type'(debounce_ticks));
      since_press_in = press_inc;
      since_hit_in = hit_inc;
      level_in = hold_press || hold_hit;
      if (touch_hit) begin
         since_hit_in = '0;
         level_in = 1'b1;
         if (!level_ff) begin
            since_press_in = '0;
         end
      end
   end

   // the previous level is the stored level, so release needs no extra flop
   assign deb_out.level = level_in;
   assign deb_out.release_pulse = level_ff && !level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         since_press_ff <= TICK_MAX;
         since_hit_ff <= TICK_MAX;
      end else if (step) begin
         level_ff <= level_in;
         since_press_ff <= since_press_in;
         since_hit_ff <= since_hit_in;
      end
   end

endmodule

// File: design/bdar_repeat.sv
module bdar_repeat
   import bdar_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       level,
   input  cfg_type    cfg,
   output rpt_ev_type events
);

   logic         edge_latched_ff, edge_latched_in;
   tick_type     repeat_count_ff, repeat_count_in;
   tick_type     accel_count_ff, accel_count_in;
   cfg_word_type accel_period_ff, accel_period_in;
   tick_type     rep_inc, acc_inc;
   logic [CFG_W+1:0] triple;
   cfg_word_type shrunk;

   // edge detect, fixed repeat and accelerating repeat counters
   always_comb begin
      rep_inc = sat_inc(repeat_count_ff);
      acc_inc = sat_inc(accel_count_ff);
      triple = {2'b00, accel_period_ff} + {1'b0, accel_period_ff, 1'b0};
      shrunk = triple[CFG_W+1:2];
      edge_latched_in = edge_latched_ff;
      repeat_count_in = repeat_count_ff;
      accel_count_in = accel_count_ff;
      accel_period_in = accel_period_ff;
      events = '0;
      if (level) begin
         if (!edge_latched_ff) begin
            edge_latched_in = 1'b1;
            events.edge_ev = 1'b1;
            repeat_count_in = '0;
            accel_count_in = '0;
            accel_period_in = cfg.accel_start_ticks;
         end else begin
            repeat_count_in = rep_inc;
            if (cmp_type'(rep_inc) >= cmp_type'(cfg.repeat_ticks)) begin
               repeat_count_in = '0;
               events.rep_ev = 1'b1;
            end
            accel_count_in = acc_inc;
            if (cmp_type'(acc_inc) >= cmp_type'(accel_period_ff)) begin
               accel_count_in = tick_type'(cmp_type'(acc_inc) - cmp_type'(accel_period_ff));
               accel_period_in = (shrunk < cfg.accel_threshold_ticks) ?
                                 cfg.accel_floor_ticks : shrunk;
               events.acc_ev = 1'b1;
            end
         end
      end else begin
         edge_latched_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_latched_ff <= 1'b0;
         repeat_count_ff <= '0;
         accel_count_ff <= '0;
         accel_period_ff <= ACCEL_START_RST;
      end else if (step) begin
         edge_latched_ff <= edge_latched_in;
         repeat_count_ff <= repeat_count_in;
         accel_count_ff <= accel_count_in;
         accel_period_ff <= accel_period_in;
      end
   end

endmodule

// File: design/button_debounce_autorepeat_core.sv
// the result word is registered and appears in the cycle after its tick word is accepted
// throughput: one tick word per cycle while rsp_ready holds, set by the single state update per tick
// a full result register still takes a new word in the cycle it is drained
// reset (synchronous, active high): level and edge low, tick counters at
// their maximum, repeat counters zero, registers at their default values
module button_debounce_autorepeat_core
   import bdar_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_touch_hit,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_is_pushed,
   output logic         rsp_release_pulse,
   output logic         rsp_key_event,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  idx_type      csr_index,
   input  cfg_word_type csr_data
);

   cfg_type     cfg_ff;
   logic        rsp_valid_ff;
   logic        is_pushed_ff, release_ff, key_event_ff;
   logic        step;
   logic        key_event_in;
   deb_out_type deb_out;
   rpt_ev_type  events;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step = req_valid && req_ready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RST;
         cfg_ff.repeat_ticks <= REPEAT_RST;
         cfg_ff.event_mode <= MODE_RST;
         cfg_ff.accel_start_ticks <= ACCEL_START_RST;
         cfg_ff.accel_floor_ticks <= ACCEL_FLOOR_RST;
         cfg_ff.accel_threshold_ticks <= ACCEL_THRESH_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DEBOUNCE: cfg_ff.debounce_ticks <= csr_data;
            REG_REPEAT: cfg_ff.repeat_ticks <= csr_data;
            REG_MODE: cfg_ff.event_mode <= csr_data[MODE_W-1:0];
            REG_ACCEL_START: cfg_ff.accel_start_ticks <= csr_data;
            REG_ACCEL_FLOOR: cfg_ff.accel_floor_ticks <= csr_data;
            REG_ACCEL_THRESH: cfg_ff.accel_threshold_ticks <= csr_data;
            default: ;
         endcase
      end
   end

   bdar_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .touch_hit      (req_touch_hit),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .deb_out        (deb_out)
   );

   bdar_repeat u_repeat (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .level  (deb_out.level),
      .cfg    (cfg_ff),
      .events (events)
   );

   // key event by mode
   always_comb begin
      unique case (cfg_ff.event_mode)
         MODE_EDGE: key_event_in = events.edge_ev;
         MODE_REPEAT: key_event_in = events.edge_ev || events.rep_ev;
         MODE_LEVEL: key_event_in = deb_out.level;
         MODE_ACCEL: key_event_in = events.edge_ev || events.acc_ev;
         default: key_event_in = 1'b0;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         is_pushed_ff <= deb_out.level;
         release_ff <= deb_out.release_pulse;
         key_event_ff <= key_event_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_is_pushed = is_pushed_ff;
   assign rsp_release_pulse = release_ff;
   assign rsp_key_event = key_event_ff;

endmodule
